// ===== hw/rtl/key_debounce_autorepeat_scanner_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Key scanner assertion macros
// Shared forms for concurrent checks, clocked on the rising edge, reset aware.
// ----------------------------------------------------------------------------
`ifndef KEY_DEBOUNCE_AUTOREPEAT_SCANNER_UNIT_DEFINES_SVH
`define KEY_DEBOUNCE_AUTOREPEAT_SCANNER_UNIT_DEFINES_SVH

// same-cycle implication
`define KDAS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KDAS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/kdas_pkg.sv =====
// ----------------------------------------------------------------------------
// Key scanner package
// Counter limits, key mapping, register codes and shared types.
// ----------------------------------------------------------------------------
package kdas_pkg;

  localparam int NUM_TRIM = 8;
  localparam int NUM_CHAN = 4;

  localparam int PRESS_W   = 6;
  localparam int REPEAT_W  = 4;
  localparam int RELEASE_W = 3;
  localparam int HOLD_W    = 5;

  localparam logic [PRESS_W-1:0]   HOLD_TICKS    = 6'd50;
  localparam logic [REPEAT_W-1:0]  REPEAT_TICKS  = 4'd15;
  localparam logic [RELEASE_W-1:0] RELEASE_TICKS = 3'd5;
  localparam logic [PRESS_W-1:0]   FIRE_TICK     = 6'd5;
  localparam logic [HOLD_W-1:0]    HOLD_REPEAT   = {1'b0, REPEAT_TICKS};
  localparam logic [HOLD_W-1:0]    HOLD_DONE     = HOLD_REPEAT + 5'd1;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    REG_LAYOUT    = 2'd0,
    REG_LONG_LOW  = 2'd1,
    REG_LONG_HIGH = 2'd2
  } reg_idx_t;

  // trim key codes
  typedef enum logic [2:0] {
    KEY_R_UP = 3'd0, KEY_R_DN = 3'd1, KEY_T_UP = 3'd2, KEY_T_DN = 3'd3,
    KEY_A_UP = 3'd4, KEY_A_DN = 3'd5, KEY_E_UP = 3'd6, KEY_E_DN = 3'd7
  } trim_code_t;

  // scan order of the trim keys; the last firing key wins
  localparam trim_code_t TRIM_ORDER [NUM_TRIM] = '{
    KEY_T_UP, KEY_T_DN, KEY_E_UP, KEY_E_DN, KEY_R_UP, KEY_R_DN, KEY_A_UP, KEY_A_DN
  };

  typedef struct packed {
    logic       trim_event_valid;
    logic [2:0] trim_key_code;
    logic       channel_event_valid;
    logic [1:0] channel_key_code;
  } kdas_result_t;

  // pin of a trim key code; layout swaps the two vertical pairs
  function automatic logic [2:0] trim_pin(input trim_code_t code, input logic layout);
    logic [2:0] pin;
    unique case (code)
      KEY_R_UP: pin = 3'd4;
      KEY_R_DN: pin = 3'd5;
      KEY_A_UP: pin = 3'd6;
      KEY_A_DN: pin = 3'd7;
      KEY_T_UP: pin = layout ? 3'd0 : 3'd2;
      KEY_T_DN: pin = layout ? 3'd1 : 3'd3;
      KEY_E_UP: pin = layout ? 3'd2 : 3'd0;
      KEY_E_DN: pin = layout ? 3'd3 : 3'd1;
      default:  pin = 3'd0;
    endcase
    return pin;
  endfunction

endpackage

// ===== hw/rtl/kdas_if.sv =====
// ----------------------------------------------------------------------------
// Key scanner channels
// Valid/ready channels for scan ticks and for key events.
// ----------------------------------------------------------------------------
interface kdas_in_if import kdas_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [NUM_TRIM-1:0] trim_keys_raw;
  logic [NUM_CHAN-1:0] channel_keys_raw;

  modport source (output valid, output trim_keys_raw, output channel_keys_raw,
                  input ready);
  modport sink   (input valid, input trim_keys_raw, input channel_keys_raw,
                  output ready);
endinterface

interface kdas_out_if;
  logic       valid;
  logic       ready;
  logic       trim_event_valid;
  logic [2:0] trim_key_code;
  logic       channel_event_valid;
  logic [1:0] channel_key_code;

  modport source (output valid, output trim_event_valid, output trim_key_code,
                  output channel_event_valid, output channel_key_code, input ready);
  modport sink   (input valid, input trim_event_valid, input trim_key_code,
                  input channel_event_valid, input channel_key_code, output ready);
endinterface

// ===== hw/rtl/kdas_trim_lane.sv =====
// ----------------------------------------------------------------------------
// Trim key lane
// Debounce and auto-repeat counters of one trim key.
// ----------------------------------------------------------------------------
module kdas_trim_lane import kdas_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic step,
  input  logic pressed,
  output logic fire
);

  logic [PRESS_W-1:0]   press_r, press_nxt;
  logic [REPEAT_W-1:0]  rep_r, rep_nxt;
  logic [RELEASE_W-1:0] rel_r, rel_nxt;
  logic [PRESS_W-1:0]   press_inc;

  assign press_inc = press_r + 6'd1;

  always_comb begin
    press_nxt = press_r;
    rep_nxt   = rep_r;
    rel_nxt   = rel_r;
    fire      = 1'b0;
    if (pressed) begin
      rel_nxt = '0;
      if (press_r < HOLD_TICKS) begin
        press_nxt = press_inc;
        rep_nxt   = '0;
        fire      = (press_inc == FIRE_TICK);
      end else if (rep_r < REPEAT_TICKS) begin
        rep_nxt = rep_r + 4'd1;
      end else begin
        rep_nxt = '0;
        fire    = 1'b1;
      end
    end else if (rel_r < RELEASE_TICKS) begin
      rel_nxt = rel_r + 3'd1;
    end else begin
      press_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_r <= '0;
      rep_r   <= '0;
      rel_r   <= '0;
    end else if (step) begin
      press_r <= press_nxt;
      rep_r   <= rep_nxt;
      rel_r   <= rel_nxt;
    end
  end

endmodule

// ===== hw/rtl/kdas_chan_lane.sv =====
// ----------------------------------------------------------------------------
// Channel key lane
// Debounce counters of one channel key, short press or single long hold.
// ----------------------------------------------------------------------------
module kdas_chan_lane import kdas_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic step,
  input  logic pressed,
  input  logic long_mode,
  output logic fire
);

  logic [PRESS_W-1:0]   press_r, press_nxt;
  logic [HOLD_W-1:0]    hold_r, hold_nxt;
  logic [RELEASE_W-1:0] rel_r, rel_nxt;
  logic [PRESS_W-1:0]   press_inc;

  assign press_inc = press_r + 6'd1;

  always_comb begin
    press_nxt = press_r;
    hold_nxt  = hold_r;
    rel_nxt   = rel_r;
    fire      = 1'b0;
    if (pressed) begin
      rel_nxt = '0;
      if (press_r < HOLD_TICKS) begin
        press_nxt = press_inc;
        hold_nxt  = '0;
        fire      = (press_inc == FIRE_TICK) && !long_mode;
      end else if (hold_r < HOLD_REPEAT) begin
        hold_nxt = hold_r + 5'd1;
      end else if (hold_r == HOLD_REPEAT) begin
        // long hold completes once, then the counter parks
        hold_nxt = HOLD_DONE;
        fire     = long_mode;
      end
    end else if (rel_r < RELEASE_TICKS) begin
      rel_nxt = rel_r + 3'd1;
    end else begin
      press_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_r <= '0;
      hold_r  <= '0;
      rel_r   <= '0;
    end else if (step) begin
      press_r <= press_nxt;
      hold_r  <= hold_nxt;
      rel_r   <= rel_nxt;
    end
  end

endmodule

// ===== hw/rtl/kdas_merge.sv =====
// ----------------------------------------------------------------------------
// Event merge
// Pick the last firing key in scan order for each key group.
// ----------------------------------------------------------------------------
module kdas_merge import kdas_pkg::*; (
  input  logic [NUM_TRIM-1:0] trim_fire,
  input  logic [NUM_CHAN-1:0] chan_fire,
  output kdas_result_t        result
);

  always_comb begin
    result = '0;
    for (int i = 0; i < NUM_TRIM; i++) begin
      if (trim_fire[TRIM_ORDER[i]]) begin
        result.trim_event_valid = 1'b1;
        result.trim_key_code    = TRIM_ORDER[i];
      end
    end
    for (int j = 0; j < NUM_CHAN; j++) begin
      if (chan_fire[j]) begin
        result.channel_event_valid = 1'b1;
        result.channel_key_code    = 2'(j);
      end
    end
  end

endmodule

// ===== hw/rtl/key_debounce_autorepeat_scanner_unit.sv =====
// ----------------------------------------------------------------------------
// Key debounce and auto-repeat scanner
// Each request is one scan tick of eight trim keys and four channel keys
// (active low). Every key has its own lane of counters, all lanes update in
// the tick's accept cycle, and the merged event appears in the output register
// on the next cycle. One request is taken every cycle while the output register
// is empty or being drained.
// Registers: layout_mode at 0x0, long_press_low_channels at 0x4,
// long_press_high_channels at 0x8, bit 0 of each.
// ----------------------------------------------------------------------------
`include "key_debounce_autorepeat_scanner_unit_defines.svh"

module key_debounce_autorepeat_scanner_unit import kdas_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  kdas_in_if.sink               in_ch,
  kdas_out_if.source            out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic layout_r, long_low_r, long_high_r;
  logic cfg_wr;
  reg_idx_t cfg_idx;

  logic step;
  logic [NUM_TRIM-1:0] trim_fire;
  logic [NUM_CHAN-1:0] chan_fire;
  kdas_result_t result;
  kdas_result_t out_r;
  logic out_valid_r;

  // configuration
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layout_r    <= 1'b0;
      long_low_r  <= 1'b0;
      long_high_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_LAYOUT:    layout_r    <= pwdata[0];
        REG_LONG_LOW:  long_low_r  <= pwdata[0];
        REG_LONG_HIGH: long_high_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_LAYOUT:    prdata[0] = layout_r;
      REG_LONG_LOW:  prdata[0] = long_low_r;
      REG_LONG_HIGH: prdata[0] = long_high_r;
      default:       prdata    = '0;
    endcase
  end

  // accept whenever the output register is free or draining
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign step        = in_ch.valid && in_ch.ready;

  for (genvar k = 0; k < NUM_TRIM; k++) begin : g_trim
    logic [2:0] pin;
    assign pin = trim_pin(trim_code_t'(k), layout_r);
    kdas_trim_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .step    (step),
      .pressed (!in_ch.trim_keys_raw[pin]),
      .fire    (trim_fire[k])
    );
  end

  for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
    kdas_chan_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .step      (step),
      .pressed   (!in_ch.channel_keys_raw[c]),
      .long_mode ((c < 2) ? long_low_r : long_high_r),
      .fire      (chan_fire[c])
    );
  end

  kdas_merge u_merge (
    .trim_fire (trim_fire),
    .chan_fire (chan_fire),
    .result    (result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_r <= result;
    end
  end

  assign out_ch.valid               = out_valid_r;
  assign out_ch.trim_event_valid    = out_r.trim_event_valid;
  assign out_ch.trim_key_code       = out_r.trim_key_code;
  assign out_ch.channel_event_valid = out_r.channel_event_valid;
  assign out_ch.channel_key_code    = out_r.channel_key_code;

  `KDAS_ASSERT_NEXT(a_tick_gives_event, clk, rst_n, step, out_valid_r, "accepted tick left no result")
  `KDAS_ASSERT_NEXT(a_trim_fire_seen, clk, rst_n, step && (|trim_fire), out_r.trim_event_valid, "trim fire lost")
  `KDAS_ASSERT_NOW(a_idle_trim_code, clk, rst_n, out_valid_r && !out_r.trim_event_valid, out_r.trim_key_code == 3'd0, "trim code set without event")

endmodule
